### design/adjacency_matrix_graph_engine_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the adjacency matrix graph engine
// Shared shorthand for clocked, reset-qualified property checks.
// ----------------------------------------------------------------------------
`ifndef ADJACENCY_MATRIX_GRAPH_ENGINE_DEFINES_SVH
`define ADJACENCY_MATRIX_GRAPH_ENGINE_DEFINES_SVH

// same-cycle implication
`define AMGE_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("graph engine check failed");

// next-cycle implication
`define AMGE_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("graph engine check failed");

`endif

### design/amge_pkg.sv
// ----------------------------------------------------------------------------
// amge_pkg
// Field widths, operation codes and transaction payload types of the engine.
// ----------------------------------------------------------------------------
package amge_pkg;

   localparam int FUNC_W  = 3;
   localparam int VTX_W   = 5;
   localparam int VAL_W   = 8;
   localparam int DEG_W   = 13;
   localparam int MAP_W   = 16;
   localparam int TOT_W   = 5;
   localparam int EDGE_W  = 15;
   localparam int TWICE_W = 16;

   // operation codes
   localparam logic [FUNC_W-1:0] FUNC_SET_COUNT     = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_LOAD_CELL     = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_INSERT_EDGE   = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_DELETE_EDGE   = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_QUERY         = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_ADD_VERTEX    = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_DELETE_VERTEX = 3'd6;

   localparam logic [TWICE_W-1:0] TWICE_MAX = 16'hFFFF;
   localparam logic [DEG_W-1:0]   DEG_MAX   = 13'h1FFF;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [VTX_W-1:0]  vertex_a;
      logic [VTX_W-1:0]  vertex_b;
      logic [VAL_W-1:0]  value;
   } req_payload_type;

   typedef struct packed {
      logic              ok;
      logic [DEG_W-1:0]  degree;
      logic [MAP_W-1:0]  neighbour_map;
      logic              is_adjacent;
      logic [TOT_W-1:0]  vertex_total;
      logic [EDGE_W-1:0] edge_total;
      logic              is_empty;
      logic              is_complete;
   } rsp_payload_type;

endpackage

### design/amge_if.sv
// ----------------------------------------------------------------------------
// amge request / response channels
// Valid/ready channels carrying one operation and one report per transaction.
// ----------------------------------------------------------------------------
interface amge_req_if;
   import amge_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface amge_rsp_if;
   import amge_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### design/amge_alu.sv
// ----------------------------------------------------------------------------
// amge_alu
// Shared signed adder with clamp to the 16-bit twice-edge counter range.
// ----------------------------------------------------------------------------
module amge_alu #(
   parameter int SUM_W = 20
) (
   input  logic signed [SUM_W-1:0]         lhs,
   input  logic signed [SUM_W-1:0]         rhs,
   output logic signed [SUM_W-1:0]         sum,
   output logic [amge_pkg::TWICE_W-1:0]    sat_sum
);
   import amge_pkg::*;

   // operands are sized so the raw sum never wraps
   assign sum = lhs + rhs;

   // clamp into 0 .. TWICE_MAX
   always_comb begin
      if (sum[SUM_W-1]) begin
         sat_sum = '0;
      end else if (sum > $signed(SUM_W'(TWICE_MAX))) begin
         sat_sum = TWICE_MAX;
      end else begin
         sat_sum = sum[TWICE_W-1:0];
      end
   end

endmodule

### design/adjacency_matrix_graph_engine.sv
// ----------------------------------------------------------------------------
// adjacency_matrix_graph_engine
// Undirected multigraph kept as a square matrix of edge multiplicities.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries one operation per transaction (set count, load cell,
//   insert edge, delete edge, query, add vertex, delete vertex). rsp_if
//   returns exactly one report per operation, taken on valid && ready.
//   The matrix sits in a single-port-write, registered-read memory; every
//   cell access is an address, then registered data, through one shared
//   adder, so the work of each operation is set by the cells it walks:
//     query / invalid op      : row walk for degree
//     load / insert / delete  : cell (a,b), mirror (b,a) for insert/delete, then row walk
//     add vertex              : row and column line clear, then row walk
//     set count               : whole-matrix clear sweep, then row walk
//     delete vertex           : lost-edge walk, matrix shift, line clear, then row walk
//   One operation is in flight at a time; req_if.ready is high only when
//   idle. The report waits in an output register, so a new operation is
//   taken while rsp_if is stalled; it finishes only once the report leaves.
//   Reset is synchronous and clears the vertex and edge counts; each cell is
//   cleared by the set count sweep or the add vertex line clear before it
//   becomes reachable.
// ----------------------------------------------------------------------------
`include "adjacency_matrix_graph_engine_defines.svh"

module adjacency_matrix_graph_engine #(
   parameter int MAX_VERTICES = 16,
   parameter int COUNT_BITS   = 8
) (
   input logic       clock,
   input logic       reset,
   amge_req_if.sink  req_if,
   amge_rsp_if.source rsp_if
);
   import amge_pkg::*;

   localparam int VB     = $clog2(MAX_VERTICES);
   localparam int CW     = $clog2(MAX_VERTICES + 1);
   localparam int DEPTH  = MAX_VERTICES * MAX_VERTICES;
   localparam int AW     = $clog2(DEPTH);
   localparam int SUM_W  = ((COUNT_BITS + VB + 3) > 18 ? (COUNT_BITS + VB + 3) : 18) + 1;
   localparam int CMP_W  = (VTX_W > CW) ? VTX_W : CW;
   localparam int WIDE_W = (VAL_W > COUNT_BITS) ? VAL_W : COUNT_BITS;
   localparam int NB_W   = (MAX_VERTICES > MAP_W) ? MAX_VERTICES : MAP_W;
   localparam int EQ_W   = (2 * CW > EDGE_W) ? 2 * CW : EDGE_W;

   localparam logic [COUNT_BITS-1:0] CELL_MAX  = '1;
   localparam logic [AW-1:0]         LAST_CELL = AW'(DEPTH - 1);
   localparam logic [AW-1:0]         LINE_MID  = AW'(MAX_VERTICES);
   localparam logic [AW-1:0]         LAST_LINE = AW'(2 * MAX_VERTICES - 1);
   localparam logic [CW-1:0]         COUNT_MAX = CW'(MAX_VERTICES);

   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_ACT, S_APPLY, S_SWEEP, S_LINE, S_RSTART, S_DONE
   } state_type;

   typedef enum logic [3:0] {
      PH_NONE, PH_LOAD, PH_INS1, PH_INS2, PH_DEL1, PH_DEL2,
      PH_LOST, PH_MOVE, PH_RPT, PH_ADD, PH_DROP
   } phase_type;

   // sequencer and datapath registers
   state_type             state_ff, state_in;
   phase_type             phase_ff, phase_in;
   logic [VTX_W-1:0]      va_ff, va_in, vb_ff, vb_in;
   logic [VAL_W-1:0]      value_ff, value_in;
   logic [VB-1:0]         a_ff, a_in, b_ff, b_in;
   logic [AW-1:0]         idx_ff, idx_in;
   logic [VB-1:0]         row_ff, row_in, col_ff, col_in, line_ff, line_in;
   logic                  ok_ff, ok_in, grew_ff, grew_in;
   logic [SUM_W-1:0]      acc_ff, acc_in;
   logic [MAX_VERTICES-1:0] nbr_ff, nbr_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [TWICE_W-1:0]    twice_ff, twice_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_ff, rsp_in;

   // matrix memory
   logic [COUNT_BITS-1:0] cell_mem [DEPTH];
   logic [COUNT_BITS-1:0] rdata_ff;
   logic                  mem_we;
   logic [AW-1:0]         wr_addr, rd_addr;
   logic [COUNT_BITS-1:0] wr_data;

   // combinational helpers
   logic                  accept;
   logic                  rsp_load;
   logic [AW-1:0]         n_aw, last_lost;
   logic [VB-1:0]         rd_row, rd_col, idx_lo, col_j, line_j, last_pos;
   logic                  diag, in_row_pass;
   logic [COUNT_BITS-1:0] new_val;
   logic signed [SUM_W-1:0] cell_ext, delta, alu_lhs, alu_rhs, alu_sum;
   logic [TWICE_W-1:0]    alu_sat;
   logic [NB_W-1:0]       nbr_wide;
   logic [CW-1:0]         count_less;
   logic [EQ_W-1:0]       pair_prod;

   function automatic logic vtx_valid(input logic [VTX_W-1:0] v, input logic [CW-1:0] n);
      vtx_valid = (v != '0) && (CMP_W'(v) <= CMP_W'(n));
   endfunction

   function automatic logic [AW-1:0] cell_addr(input logic [VB-1:0] r, input logic [VB-1:0] c);
      cell_addr = AW'(r) * AW'(MAX_VERTICES) + AW'(c);
   endfunction

   amge_alu #(.SUM_W(SUM_W)) u_alu (
      .lhs     (alu_lhs),
      .rhs     (alu_rhs),
      .sum     (alu_sum),
      .sat_sum (alu_sat)
   );

   assign req_if.ready   = (state_ff == S_IDLE);
   assign accept         = req_if.valid && (state_ff == S_IDLE);
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_ff;

   // report register loads in this cycle
   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_if.ready);

   // walk positions
   assign n_aw        = AW'(count_ff);
   assign last_lost   = (n_aw << 1) - AW'(1);
   assign idx_lo      = idx_ff[VB-1:0];
   assign col_j       = VB'(idx_ff - n_aw);
   assign line_j      = VB'(idx_ff - LINE_MID);
   assign in_row_pass = (idx_ff < n_aw);
   assign last_pos    = VB'(count_ff - CW'(2));

   // read address select
   always_comb begin
      rd_row = '0;
      rd_col = '0;
      case (phase_ff)
         PH_LOAD, PH_INS1, PH_DEL1: begin
            rd_row = a_ff;
            rd_col = b_ff;
         end
         PH_INS2, PH_DEL2: begin
            rd_row = b_ff;
            rd_col = a_ff;
         end
         PH_LOST: begin
            rd_row = in_row_pass ? a_ff : col_j;
            rd_col = in_row_pass ? idx_lo : a_ff;
         end
         PH_MOVE: begin
            rd_row = row_ff + VB'(row_ff >= a_ff);
            rd_col = col_ff + VB'(col_ff >= a_ff);
         end
         PH_RPT: begin
            rd_row = a_ff;
            rd_col = idx_lo;
         end
         default: begin
            rd_row = '0;
            rd_col = '0;
         end
      endcase
   end

   assign rd_addr  = cell_addr(rd_row, rd_col);
   assign diag     = (rd_row == rd_col);
   assign cell_ext = $signed(SUM_W'(rdata_ff));
   assign new_val  = (WIDE_W'(value_ff) > WIDE_W'(CELL_MAX)) ? CELL_MAX
                                                             : COUNT_BITS'(value_ff);

   // shared adder operand select
   always_comb begin
      alu_lhs = $signed(SUM_W'(twice_ff));
      alu_rhs = '0;
      delta   = '0;
      if (state_ff == S_ACT) begin
         case (phase_ff)
            PH_LOAD: begin
               delta   = $signed(SUM_W'(new_val)) - cell_ext;
               alu_rhs = diag ? (delta <<< 1) : delta;
            end
            PH_INS1, PH_INS2: begin
               alu_rhs = diag ? SUM_W'(2) : SUM_W'(1);
            end
            PH_DEL1, PH_DEL2: begin
               delta   = -cell_ext;
               alu_rhs = diag ? (delta <<< 1) : delta;
            end
            PH_LOST: begin
               alu_lhs = $signed(acc_ff);
               if (in_row_pass) begin
                  alu_rhs = diag ? (cell_ext <<< 1) : cell_ext;
               end else begin
                  alu_rhs = diag ? '0 : cell_ext;
               end
            end
            PH_RPT: begin
               alu_lhs = $signed(acc_ff);
               alu_rhs = diag ? (cell_ext <<< 1) : cell_ext;
            end
            default: begin
               alu_rhs = '0;
            end
         endcase
      end else if (state_ff == S_APPLY) begin
         alu_rhs = -$signed(acc_ff);
      end
   end

   // report fields
   assign nbr_wide   = NB_W'(nbr_ff);
   assign count_less = (count_ff == '0) ? '0 : count_ff - CW'(1);
   assign pair_prod  = EQ_W'(count_ff) * EQ_W'(count_less);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      va_in        = va_ff;
      vb_in        = vb_ff;
      value_in     = value_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      idx_in       = idx_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      line_in      = line_ff;
      ok_in        = ok_ff;
      grew_in      = grew_ff;
      acc_in       = acc_ff;
      nbr_in       = nbr_ff;
      count_in     = count_ff;
      twice_in     = twice_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      wr_addr      = rd_addr;
      wr_data      = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               va_in    = req_if.payload.vertex_a;
               vb_in    = req_if.payload.vertex_b;
               value_in = req_if.payload.value;
               a_in     = VB'(req_if.payload.vertex_a - VTX_W'(1));
               b_in     = VB'(req_if.payload.vertex_b - VTX_W'(1));
               ok_in    = 1'b0;
               grew_in  = 1'b0;
               idx_in   = '0;
               acc_in   = '0;
               phase_in = PH_NONE;
               state_in = S_RSTART;
               case (req_if.payload.func)
                  FUNC_SET_COUNT: begin
                     if (req_if.payload.value <= VAL_W'(MAX_VERTICES)) begin
                        state_in = S_SWEEP;
                     end
                  end
                  FUNC_LOAD_CELL, FUNC_INSERT_EDGE, FUNC_DELETE_EDGE: begin
                     if (vtx_valid(req_if.payload.vertex_a, count_ff) &&
                         vtx_valid(req_if.payload.vertex_b, count_ff)) begin
                        state_in = S_READ;
                        if (req_if.payload.func == FUNC_LOAD_CELL) begin
                           phase_in = PH_LOAD;
                        end else if (req_if.payload.func == FUNC_INSERT_EDGE) begin
                           phase_in = PH_INS1;
                        end else begin
                           phase_in = PH_DEL1;
                        end
                     end
                  end
                  FUNC_QUERY: begin
                     ok_in = vtx_valid(req_if.payload.vertex_a, count_ff);
                  end
                  FUNC_ADD_VERTEX: begin
                     if (count_ff < COUNT_MAX) begin
                        line_in  = VB'(count_ff);
                        phase_in = PH_ADD;
                        state_in = S_LINE;
                     end
                  end
                  FUNC_DELETE_VERTEX: begin
                     if (vtx_valid(req_if.payload.vertex_a, count_ff)) begin
                        phase_in = PH_LOST;
                        state_in = S_READ;
                     end
                  end
                  default: begin
                     state_in = S_RSTART;
                  end
               endcase
            end
         end

         S_READ: begin
            state_in = S_ACT;
         end

         S_ACT: begin
            case (phase_ff)
               PH_LOAD: begin
                  mem_we   = 1'b1;
                  wr_data  = new_val;
                  twice_in = alu_sat;
                  ok_in    = 1'b1;
                  state_in = S_RSTART;
               end
               PH_INS1, PH_INS2: begin
                  if (rdata_ff != CELL_MAX) begin
                     mem_we   = 1'b1;
                     wr_data  = rdata_ff + COUNT_BITS'(1);
                     twice_in = alu_sat;
                  end
                  if ((phase_ff == PH_INS1) && (a_ff != b_ff)) begin
                     grew_in  = (rdata_ff != CELL_MAX);
                     phase_in = PH_INS2;
                     state_in = S_READ;
                  end else begin
                     ok_in    = grew_ff || (rdata_ff != CELL_MAX);
                     state_in = S_RSTART;
                  end
               end
               PH_DEL1: begin
                  mem_we   = 1'b1;
                  twice_in = alu_sat;
                  phase_in = PH_DEL2;
                  state_in = S_READ;
               end
               PH_DEL2: begin
                  mem_we   = 1'b1;
                  twice_in = alu_sat;
                  ok_in    = 1'b1;
                  state_in = S_RSTART;
               end
               PH_LOST: begin
                  acc_in = alu_sum;
                  if (idx_ff == last_lost) begin
                     state_in = S_APPLY;
                  end else begin
                     idx_in   = idx_ff + AW'(1);
                     state_in = S_READ;
                  end
               end
               PH_MOVE: begin
                  // row-major copy never overwrites a cell still to be read
                  mem_we   = 1'b1;
                  wr_addr  = cell_addr(row_ff, col_ff);
                  wr_data  = rdata_ff;
                  state_in = S_READ;
                  if (col_ff == last_pos) begin
                     col_in = '0;
                     if (row_ff == last_pos) begin
                        line_in  = VB'(count_less);
                        idx_in   = '0;
                        phase_in = PH_DROP;
                        state_in = S_LINE;
                     end else begin
                        row_in = row_ff + VB'(1);
                     end
                  end else begin
                     col_in = col_ff + VB'(1);
                  end
               end
               PH_RPT: begin
                  acc_in         = alu_sum;
                  nbr_in[idx_lo] = (rdata_ff != '0);
                  if (idx_ff == AW'(count_less)) begin
                     state_in = S_DONE;
                  end else begin
                     idx_in   = idx_ff + AW'(1);
                     state_in = S_READ;
                  end
               end
               default: begin
                  state_in = S_RSTART;
               end
            endcase
         end

         // remove the deleted vertex's edges from the counter
         S_APPLY: begin
            twice_in = alu_sat;
            row_in   = '0;
            col_in   = '0;
            idx_in   = '0;
            if (count_ff == CW'(1)) begin
               line_in  = '0;
               phase_in = PH_DROP;
               state_in = S_LINE;
            end else begin
               phase_in = PH_MOVE;
               state_in = S_READ;
            end
         end

         // clear the whole matrix
         S_SWEEP: begin
            mem_we  = 1'b1;
            wr_addr = idx_ff;
            if (idx_ff == LAST_CELL) begin
               count_in = CW'(value_ff);
               twice_in = '0;
               ok_in    = 1'b1;
               state_in = S_RSTART;
            end else begin
               idx_in = idx_ff + AW'(1);
            end
         end

         // clear one row, then one column
         S_LINE: begin
            mem_we  = 1'b1;
            wr_addr = (idx_ff < LINE_MID) ? cell_addr(line_ff, idx_lo)
                                          : cell_addr(line_j, line_ff);
            if (idx_ff == LAST_LINE) begin
               count_in = (phase_ff == PH_ADD) ? count_ff + CW'(1) : count_less;
               ok_in    = 1'b1;
               state_in = S_RSTART;
            end else begin
               idx_in = idx_ff + AW'(1);
            end
         end

         S_RSTART: begin
            idx_in = '0;
            acc_in = '0;
            nbr_in = '0;
            if (vtx_valid(va_ff, count_ff)) begin
               phase_in = PH_RPT;
               state_in = S_READ;
            end else begin
               phase_in = PH_NONE;
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in         = 1'b1;
               rsp_in.ok            = ok_ff;
               rsp_in.degree        = (acc_ff > SUM_W'(DEG_MAX)) ? DEG_MAX : DEG_W'(acc_ff);
               rsp_in.neighbour_map = nbr_wide[MAP_W-1:0];
               rsp_in.is_adjacent   = vtx_valid(va_ff, count_ff) &&
                                      vtx_valid(vb_ff, count_ff) && nbr_ff[b_ff];
               rsp_in.vertex_total  = TOT_W'(count_ff);
               rsp_in.edge_total    = EDGE_W'(twice_ff >> 1);
               rsp_in.is_empty      = (count_ff == '0);
               rsp_in.is_complete   = (EQ_W'(twice_ff >> 1) == (pair_prod >> 1));
               state_in             = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_NONE;
         count_ff     <= '0;
         twice_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         twice_ff     <= twice_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      va_ff    <= va_in;
      vb_ff    <= vb_in;
      value_ff <= value_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      idx_ff   <= idx_in;
      row_ff   <= row_in;
      col_ff   <= col_in;
      line_ff  <= line_in;
      ok_ff    <= ok_in;
      grew_ff  <= grew_in;
      acc_ff   <= acc_in;
      nbr_ff   <= nbr_in;
      rsp_ff   <= rsp_in;
   end

   // matrix memory: one write port, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         cell_mem[wr_addr] <= wr_data;
      end
      rdata_ff <= cell_mem[rd_addr];
   end

   // checks
   `AMGE_ASSERT_IMPLY(a_count_range, 1'b1, count_ff <= COUNT_MAX)
   `AMGE_ASSERT_NEXT(a_busy_after_accept, accept, !req_if.ready)
   `AMGE_ASSERT_NEXT(a_rsp_from_done, rsp_load, rsp_valid_ff && (state_ff == S_IDLE))
   `AMGE_ASSERT_IMPLY(a_no_write_idle, state_ff == S_IDLE, !mem_we)

endmodule

### tb/tb_adjacency_matrix_graph_engine.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_adjacency_matrix_graph_engine
// Self-checking bench: a directed table of corner operations, then a
// random walk of graph operations, each report checked against a model
// of the multigraph kept in the bench or, for typed rows, a literal report.
// ----------------------------------------------------------------------------
module tb_adjacency_matrix_graph_engine;
   import amge_pkg::*;

   localparam int NVTX       = 16;
   localparam int CELL_TOP   = 255;
   localparam int RAND_ITEMS = 850;
   localparam int IDLE_LIMIT = 20000;
   localparam int FUNC_UNKNOWN = 7;

   logic clock = 1'b0;
   logic reset = 1'b1;

   amge_req_if req_bus ();
   amge_rsp_if rsp_bus ();

   adjacency_matrix_graph_engine i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   always #10 clock = ~clock;

   // graph model state
   logic [7:0] mx_cell [NVTX][NVTX];
   int         mx_count;
   int         mx_twice;

   rsp_payload_type report_fifo[$];
   int  sender_idle_pct;
   int  receiver_idle_pct;
   bit  stim_done;
   int  mismatches;
   int  idle_cycles;
   int  op_hits [8];
   int  reports_seen;

   // ----- graph model -------------------------------------------------------
   function automatic bit vtx_valid(int v);
      return v >= 1 && v <= mx_count;
   endfunction

   function automatic void bump_twice(int delta);
      mx_twice = mx_twice + delta;
      if (mx_twice < 0) mx_twice = 0;
      if (mx_twice > 65535) mx_twice = 65535;
   endfunction

   function automatic void put_weighted(int r, int c, int v);
      int w;
      w = (r == c) ? 2 : 1;
      bump_twice(w * (v - int'(mx_cell[r][c])));
      mx_cell[r][c] = v[7:0];
   endfunction

   function automatic bit grow_cell(int r, int c);
      if (mx_cell[r][c] >= CELL_TOP) return 1'b0;
      put_weighted(r, c, int'(mx_cell[r][c]) + 1);
      return 1'b1;
   endfunction

   function automatic void clear_line(int k);
      for (int i = 0; i < NVTX; i++) begin
         mx_cell[k][i] = '0;
         mx_cell[i][k] = '0;
      end
   endfunction

   function automatic rsp_payload_type graph_predict(req_payload_type r);
      rsp_payload_type rsp;
      logic [7:0] snap [NVTX][NVTX];
      int va, vb, a, b, n, deg, lost, si, sj, edges;
      bit ok, g1, g2;
      logic [15:0] map;
      va = int'(r.vertex_a); vb = int'(r.vertex_b);
      a = va - 1; b = vb - 1;
      ok = 1'b0;
      case (r.func)
         FUNC_SET_COUNT: if (int'(r.value) <= NVTX) begin
            for (int i = 0; i < NVTX; i++)
               for (int j = 0; j < NVTX; j++) mx_cell[i][j] = '0;
            mx_count = int'(r.value);
            mx_twice = 0;
            ok = 1'b1;
         end
         FUNC_LOAD_CELL: if (vtx_valid(va) && vtx_valid(vb)) begin
            put_weighted(a, b, int'(r.value));
            ok = 1'b1;
         end
         FUNC_INSERT_EDGE: if (vtx_valid(va) && vtx_valid(vb)) begin
            if (a == b) begin
               if (mx_cell[a][a] < CELL_TOP) begin
                  mx_cell[a][a] = mx_cell[a][a] + 8'd1;
                  bump_twice(2);
                  ok = 1'b1;
               end
            end else begin
               g1 = grow_cell(a, b);
               g2 = grow_cell(b, a);
               ok = g1 || g2;
            end
         end
         FUNC_DELETE_EDGE: if (vtx_valid(va) && vtx_valid(vb)) begin
            put_weighted(a, b, 0);
            put_weighted(b, a, 0);
            ok = 1'b1;
         end
         FUNC_QUERY: ok = vtx_valid(va);
         FUNC_ADD_VERTEX: if (mx_count < NVTX) begin
            clear_line(mx_count);
            mx_count++;
            ok = 1'b1;
         end
         FUNC_DELETE_VERTEX: if (vtx_valid(va)) begin
            n = mx_count;
            lost = 2 * int'(mx_cell[a][a]);
            for (int i = 0; i < n; i++)
               if (i != a) lost += int'(mx_cell[a][i]) + int'(mx_cell[i][a]);
            bump_twice(-lost);
            snap = mx_cell;
            // rows and columns past the victim shift down by one
            for (int i = 0; i + 1 < n; i++) begin
               si = i + ((i >= a) ? 1 : 0);
               for (int j = 0; j + 1 < n; j++) begin
                  sj = j + ((j >= a) ? 1 : 0);
                  mx_cell[i][j] = snap[si][sj];
               end
            end
            clear_line(n - 1);
            mx_count = n - 1;
            ok = 1'b1;
         end
         default: ok = 1'b0;
      endcase

      // report on the graph after the operation
      n = mx_count;
      deg = 0;
      map = '0;
      rsp = '0;
      if (vtx_valid(va)) begin
         for (int i = 0; i < n; i++) begin
            deg += (i == a) ? 2 * int'(mx_cell[a][i]) : int'(mx_cell[a][i]);
            if (mx_cell[a][i] != 0) map[i] = 1'b1;
         end
         if (deg > 8191) deg = 8191;
         if (vtx_valid(vb) && mx_cell[a][b] != 0) rsp.is_adjacent = 1'b1;
      end
      edges = mx_twice / 2;
      rsp.ok            = ok;
      rsp.degree        = deg[DEG_W-1:0];
      rsp.neighbour_map = map;
      rsp.vertex_total  = n[TOT_W-1:0];
      rsp.edge_total    = edges[EDGE_W-1:0];
      rsp.is_empty      = (n == 0);
      rsp.is_complete   = (edges == n * (n - ((n != 0) ? 1 : 0)) / 2);
      return rsp;
   endfunction

   // ----- directed table ----------------------------------------------------
   typedef struct {
      req_payload_type req;
      bit              typed;
      rsp_payload_type want;
   } dir_row_type;

   dir_row_type dir_rows[$];

   function automatic void add_row(int f, int va, int vb, int val);
      dir_row_type row;
      row.req.func = FUNC_W'(f); row.req.vertex_a = VTX_W'(va);
      row.req.vertex_b = VTX_W'(vb);
      row.req.value = VAL_W'(val);
      row.typed = 1'b0;
      row.want = '0;
      dir_rows.push_back(row);
   endfunction

   // same as add_row but with the report given literally
   function automatic void add_typed(int f, int va, int vb, int val, bit ok,
                                     int vtot, bit empty, bit complete);
      add_row(f, va, vb, val);
      dir_rows[$].typed = 1'b1;
      dir_rows[$].want.ok = ok;
      dir_rows[$].want.vertex_total = TOT_W'(vtot);
      dir_rows[$].want.is_empty = empty;
      dir_rows[$].want.is_complete = complete;
   endfunction

   // ----- sender ------------------------------------------------------------
   task automatic send_op(req_payload_type r, bit typed, rsp_payload_type want);
      rsp_payload_type predicted;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.payload <= r;
      do @(posedge clock); while (!req_bus.ready);
      predicted = graph_predict(r);
      report_fifo.push_back(typed ? want : predicted);
      op_hits[r.func]++;
      @(negedge clock);
   endtask

   function automatic int pick_vertex();
      int roll;
      roll = $urandom_range(99);
      if (roll < 6) return $urandom_range(31);
      if (roll < 10) return mx_count + 1;
      if (mx_count == 0) return $urandom_range(2);
      return $urandom_range(mx_count, 1);
   endfunction

   function automatic req_payload_type random_op();
      req_payload_type r;
      int roll;
      roll = $urandom_range(99);
      r.vertex_a = VTX_W'(pick_vertex());
      r.vertex_b = VTX_W'(pick_vertex());
      r.value    = VAL_W'($urandom_range(255));
      if (roll < 4) begin
         r.func = FUNC_SET_COUNT;
         if ($urandom_range(3) != 0) r.value = VAL_W'($urandom_range(NVTX, 2));
      end else if (roll < 16) r.func = FUNC_LOAD_CELL;
      else if (roll < 48) r.func = FUNC_INSERT_EDGE;
      else if (roll < 58) r.func = FUNC_DELETE_EDGE;
      else if (roll < 74) r.func = FUNC_QUERY;
      else if (roll < 86) r.func = FUNC_ADD_VERTEX;
      else if (roll < 98) r.func = FUNC_DELETE_VERTEX;
      else r.func = FUNC_W'(FUNC_UNKNOWN);
      // keep small loads common so edges stay countable
      if (r.func == FUNC_LOAD_CELL && $urandom_range(1)) r.value = VAL_W'($urandom_range(4));
      return r;
   endfunction

   // ----- receiver stalls ---------------------------------------------------
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   // ----- report checker ----------------------------------------------------
   task automatic flag_bad(string what, int want_v, int got_v);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: report %0d %s expected %0d got %0d",
                  $realtime, reports_seen, what, want_v, got_v);
   endtask

   always @(posedge clock) begin
      rsp_payload_type got, want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = rsp_bus.payload;
         reports_seen++;
         if (report_fifo.size() == 0) begin
            flag_bad("unexpected transaction, ok", 0, int'(got.ok));
         end else begin
            want = report_fifo.pop_front();
            if (got.ok !== want.ok) flag_bad("ok", int'(want.ok), int'(got.ok));
            if (got.degree !== want.degree)
               flag_bad("degree", int'(want.degree), int'(got.degree));
            if (got.neighbour_map !== want.neighbour_map)
               flag_bad("neighbour_map", int'(want.neighbour_map),
                        int'(got.neighbour_map));
            if (got.is_adjacent !== want.is_adjacent)
               flag_bad("is_adjacent", int'(want.is_adjacent), int'(got.is_adjacent));
            if (got.vertex_total !== want.vertex_total)
               flag_bad("vertex_total", int'(want.vertex_total), int'(got.vertex_total));
            if (got.edge_total !== want.edge_total)
               flag_bad("edge_total", int'(want.edge_total), int'(got.edge_total));
            if (got.is_empty !== want.is_empty)
               flag_bad("is_empty", int'(want.is_empty), int'(got.is_empty));
            if (got.is_complete !== want.is_complete)
               flag_bad("is_complete", int'(want.is_complete), int'(got.is_complete));
         end
      end
   end

   // ----- watchdog ----------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) ||
          (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("adjacency_matrix_graph_engine regression: fail");
            $finish;
         end
      end
   end

   // ----- main sequence -----------------------------------------------------
   initial begin
      rsp_payload_type none;
      int third;
      none = '0;
      req_bus.valid   = 1'b0;
      req_bus.payload = '0;
      rsp_bus.ready   = 1'b0;
      sender_idle_pct = 7;
      receiver_idle_pct = 84;
      mismatches = 0;
      idle_cycles = 0;
      reports_seen = 0;
      stim_done = 1'b0;
      for (int i = 0; i < 8; i++) op_hits[i] = 0;
      for (int i = 0; i < NVTX; i++)
         for (int j = 0; j < NVTX; j++) mx_cell[i][j] = '0;
      mx_count = 0;
      mx_twice = 0;

      // empty graph and count limits
      add_typed(FUNC_QUERY, 1, 1, 0, 0, 0, 1, 1);
      add_typed(FUNC_SET_COUNT, 0, 0, 17, 0, 0, 1, 1);
      add_typed(FUNC_SET_COUNT, 31, 31, 255, 0, 0, 1, 1);
      add_typed(FUNC_SET_COUNT, 0, 0, NVTX, 1, NVTX, 0, 0);
      add_typed(FUNC_UNKNOWN, 0, 0, 0, 0, NVTX, 0, 0);
      // saturated self-loop and cell
      add_row(FUNC_LOAD_CELL, 16, 16, 255);
      add_row(FUNC_INSERT_EDGE, 16, 16, 0);
      add_row(FUNC_INSERT_EDGE, 1, 2, 0);
      add_row(FUNC_INSERT_EDGE, 2, 1, 0);
      add_row(FUNC_LOAD_CELL, 1, 2, 255);
      add_row(FUNC_INSERT_EDGE, 1, 2, 0);
      add_row(FUNC_INSERT_EDGE, 1, 2, 0);
      add_row(FUNC_DELETE_EDGE, 2, 1, 0);
      add_row(FUNC_INSERT_EDGE, 3, 3, 0);
      add_row(FUNC_QUERY, 17, 31, 0);
      add_row(FUNC_ADD_VERTEX, 0, 0, 0);
      add_row(FUNC_DELETE_VERTEX, 3, 0, 0);
      add_row(FUNC_DELETE_VERTEX, 15, 1, 0);
      add_row(FUNC_DELETE_VERTEX, 0, 0, 0);
      add_row(FUNC_ADD_VERTEX, 15, 15, 0);
      add_row(FUNC_SET_COUNT, 0, 0, 0);
      add_row(FUNC_ADD_VERTEX, 1, 1, 170);
      add_row(FUNC_INSERT_EDGE, 1, 1, 85);
      add_row(FUNC_DELETE_VERTEX, 1, 1, 0);
      add_row(FUNC_DELETE_VERTEX, 1, 1, 0);

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_rows[i]) send_op(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);

      // random walk in three idling phases
      third = RAND_ITEMS / 3;
      for (int k = 0; k < RAND_ITEMS; k++) begin
         if (k == third) begin
            sender_idle_pct = 84;
            receiver_idle_pct = 7;
         end else if (k == 2 * third) begin
            sender_idle_pct = 0;
            receiver_idle_pct = 0;
         end
         send_op(random_op(), 1'b0, none);
      end
      req_bus.valid <= 1'b0;
      stim_done = 1'b1;

      wait (report_fifo.size() == 0);
      repeat (700) @(posedge clock);

      $display("covered %0d set count, %0d load, %0d insert, %0d delete edge,",
               op_hits[0], op_hits[1], op_hits[2], op_hits[3]);
      $display("  %0d query, %0d add vertex, %0d delete vertex, %0d unknown; %0d reports",
               op_hits[4], op_hits[5], op_hits[6], op_hits[7], reports_seen);
      if (mismatches == 0 && report_fifo.size() == 0) begin
         $display("adjacency_matrix_graph_engine regression: pass");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("adjacency_matrix_graph_engine regression: fail");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+design
design/amge_pkg.sv
design/amge_if.sv
design/amge_alu.sv
design/adjacency_matrix_graph_engine.sv
tb/tb_adjacency_matrix_graph_engine.sv
